### rtl/core/last_note_priority_stack_assert.svh
// Assertion macros shared by the note stack RTL
`ifndef LAST_NOTE_PRIORITY_STACK_ASSERT_SVH
`define LAST_NOTE_PRIORITY_STACK_ASSERT_SVH

// check cons in the same cycle as ante
`define LNPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define LNPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lnps_pkg.sv
// Types and constants of the last-note-priority note stack
`default_nettype none
package lnps_pkg;

    localparam int CHAN_W = 4;
    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int HELD_W = 5;

    localparam logic CMD_NOTE_ON  = 1'b0;
    localparam logic CMD_NOTE_OFF = 1'b1;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef enum logic
    {
        OP_NOTE_ON,
        OP_NOTE_OFF
    } op_t;

    typedef enum logic [1:0]
    {
        ACT_NONE    = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_RELEASE = 2'd2
    } action_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_TOP,
        ST_NEWTOP,
        ST_SEARCH,
        ST_SHIFT,
        ST_PUT
    } state_t;

    typedef struct packed
    {
        op_t               op;
        logic [CHAN_W-1:0] chan;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } lnps_item_t;

    typedef struct packed
    {
        action_t           action;
        logic [CHAN_W-1:0] chan;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic [HELD_W-1:0] held;
        logic              ovf;
    } lnps_res_t;

endpackage
`default_nettype wire

### rtl/core/lnps_front.sv
// Front end: event intake, command decode and the short event queue
`default_nettype none
module lnps_front
    import lnps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              cmd,
    input  wire logic [CHAN_W-1:0] chan,
    input  wire logic [NOTE_W-1:0] note,
    input  wire logic [VEL_W-1:0]  vel,
    output lnps_item_t             item,
    output logic                   item_valid,
    input  wire logic              item_take
);

    lnps_item_t       q_mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QAW:0]     cnt_reg;
    logic [QAW:0]     cnt_next;
    logic             do_push;
    logic             do_pop;
    lnps_item_t       new_item;

    assign full       = (cnt_reg == (QAW+1)'(QDEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        new_item.op   = (cmd == CMD_NOTE_OFF) ? OP_NOTE_OFF : OP_NOTE_ON;
        new_item.chan = chan;
        new_item.note = note;
        new_item.vel  = vel;
    end

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule
`default_nettype wire

### rtl/core/lnps_back.sv
// Back end: note stack memory, stack sequencer and result register
`default_nettype none
module lnps_back
    import lnps_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lnps_item_t item,
    input  wire logic       item_valid,
    output logic            item_take,
    output lnps_res_t       res,
    output logic            empty,
    input  wire logic       pop
);

    `include "last_note_priority_stack_assert.svh"

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [NOTE_W-1:0] mem [STACK_DEPTH];
    logic [NOTE_W-1:0] rd_data_reg;

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     ptr_next;
    logic [AW-1:0]     last_reg;
    logic [AW-1:0]     last_next;
    lnps_item_t        item_reg;
    lnps_item_t        item_next;
    lnps_res_t         res_reg;
    lnps_res_t         res_next;
    logic              res_valid_reg;
    logic              res_valid_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [NOTE_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    logic              pop_ok;
    logic              slot_free;
    logic              is_full;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic [CW-1:0]     res_cnt;

    assign pop_ok    = pop && res_valid_reg;
    assign slot_free = !res_valid_reg || pop;
    assign is_full   = (count_reg == CW'(STACK_DEPTH));
    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_m2    = count_reg - CW'(2);
    assign empty     = !res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        last_next      = last_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop_ok;
        res_cnt        = count_reg;
        item_take      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = rd_data_reg;
        mem_raddr      = ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && slot_free)
                begin
                    item_take = 1'b1;
                    item_next = item;
                    case (item.op)
                        OP_NOTE_ON:
                        begin
                            if (is_full)
                            begin
                                ptr_next   = '0;
                                last_next  = AW'(STACK_DEPTH - 2);
                                mem_raddr  = AW'(1);
                                state_next = ST_SHIFT;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = count_reg[AW-1:0];
                                mem_wdata      = item.note;
                                count_next     = count_reg + CW'(1);
                                res_cnt        = count_reg + CW'(1);
                                res_next       = '0;
                                res_next.action = ACT_TRIGGER;
                                res_next.chan  = item.chan;
                                res_next.note  = item.note;
                                res_next.vel   = item.vel;
                                res_valid_next = 1'b1;
                            end
                        end
                        OP_NOTE_OFF:
                        begin
                            if (count_reg == '0)
                            begin
                                res_cnt        = count_reg;
                                res_next       = '0;
                                res_next.action = ACT_NONE;
                                res_next.chan  = item.chan;
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = cnt_m1[AW-1:0];
                                state_next = ST_TOP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_TOP:
            begin
                res_next      = '0;
                res_next.chan = item_reg.chan;
                if (rd_data_reg == item_reg.note)
                begin
                    count_next = cnt_m1;
                    if (count_reg == CW'(1))
                    begin
                        res_cnt         = cnt_m1;
                        res_next.action = ACT_RELEASE;
                        res_next.note   = item_reg.note;
                        res_next.vel    = item_reg.vel;
                        res_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        mem_raddr  = cnt_m2[AW-1:0];
                        state_next = ST_NEWTOP;
                    end
                end
                else if (count_reg == CW'(1))
                begin
                    res_cnt         = count_reg;
                    res_next.action = ACT_NONE;
                    res_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    ptr_next   = cnt_m2[AW-1:0];
                    mem_raddr  = cnt_m2[AW-1:0];
                    state_next = ST_SEARCH;
                end
            end

            ST_NEWTOP:
            begin
                res_cnt         = count_reg;
                res_next        = '0;
                res_next.action = ACT_TRIGGER;
                res_next.chan   = item_reg.chan;
                res_next.note   = rd_data_reg;
                res_next.vel    = item_reg.vel;
                res_valid_next  = 1'b1;
                state_next      = ST_IDLE;
            end

            ST_SEARCH:
            begin
                if (rd_data_reg == item_reg.note)
                begin
                    last_next  = cnt_m2[AW-1:0];
                    mem_raddr  = ptr_reg + AW'(1);
                    state_next = ST_SHIFT;
                end
                else if (ptr_reg == '0)
                begin
                    res_cnt         = count_reg;
                    res_next        = '0;
                    res_next.action = ACT_NONE;
                    res_next.chan   = item_reg.chan;
                    res_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    ptr_next  = ptr_reg - AW'(1);
                    mem_raddr = ptr_reg - AW'(1);
                end
            end

            ST_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rd_data_reg;
                if (ptr_reg == last_reg)
                begin
                    if (item_reg.op == OP_NOTE_ON)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        count_next      = cnt_m1;
                        res_cnt         = cnt_m1;
                        res_next        = '0;
                        res_next.action = ACT_NONE;
                        res_next.chan   = item_reg.chan;
                        res_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    ptr_next  = ptr_reg + AW'(1);
                    mem_raddr = ptr_reg + AW'(2);
                end
            end

            ST_PUT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = AW'(STACK_DEPTH - 1);
                mem_wdata       = item_reg.note;
                res_cnt         = count_reg;
                res_next        = '0;
                res_next.action = ACT_TRIGGER;
                res_next.chan   = item_reg.chan;
                res_next.note   = item_reg.note;
                res_next.vel    = item_reg.vel;
                res_next.ovf    = 1'b1;
                res_valid_next  = 1'b1;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_valid_next && !(res_valid_reg && !pop_ok))
        begin
            res_next.held = HELD_W'({{HELD_W{1'b0}}, res_cnt});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        last_reg <= last_next;
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    `LNPS_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(STACK_DEPTH), "stack count past depth")
    `LNPS_ASSERT_NOW(a_busy_no_word, state_reg != ST_IDLE, !res_valid_reg,
        "word waiting while busy")
    `LNPS_ASSERT_NOW(a_ovf_full, res_valid_reg && res_reg.ovf, is_full,
        "overflow without full stack")
    `LNPS_ASSERT_NOW(a_release_empty, res_valid_reg && (res_reg.action == ACT_RELEASE),
        count_reg == '0, "release with notes held")
    `LNPS_ASSERT_NOW(a_shift_bound, state_reg == ST_SHIFT, ptr_reg <= last_reg, "shift past last entry")

endmodule
`default_nettype wire

### rtl/core/last_note_priority_stack.sv
// Top level of the last-note-priority note stack for a monophonic voice
//
// Events enter through a queue port: drive cmd, chan, note and vel with push
// high; a word is taken at each rising edge with push high and full low.
// Results leave through a queue port: while empty is low the oldest result
// sits on action, out_chan, out_note, out_vel, held_count and overflow, and
// pop high at a rising edge takes it. Every event yields exactly one result.
// A note-on on a stack that is not full is stored at once; a note-off
// reads the top entry and, if notes remain, the new top; a note-on on a
// full stack shifts every entry down over the oldest; a note-off found
// deeper is searched for downward and the entries above it shifted down.
// The sequencer does one stack memory read and one write per cycle. It
// takes the next event once idle with the result slot free, so note-ons on
// a stack that is not full run at one per cycle while results are popped.
// A two-word event queue keeps taking words while the sequencer works or
// while a result waits; once the result register holds an unpopped word the
// sequencer waits and full rises once two events wait in the queue.
// Reset clears the stack count and both queues; stack entries are written
// before they are ever read, so the stack memory needs no clearing pass.
`default_nettype none
module last_note_priority_stack
    import lnps_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              cmd,
    input  wire logic [CHAN_W-1:0] chan,
    input  wire logic [NOTE_W-1:0] note,
    input  wire logic [VEL_W-1:0]  vel,
    output logic                   empty,
    input  wire logic              pop,
    output logic [1:0]             action,
    output logic [CHAN_W-1:0]      out_chan,
    output logic [NOTE_W-1:0]      out_note,
    output logic [VEL_W-1:0]       out_vel,
    output logic [HELD_W-1:0]      held_count,
    output logic                   overflow
);

    lnps_item_t item;
    logic       item_valid;
    logic       item_take;
    lnps_res_t  res;

    lnps_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .chan       (chan),
        .note       (note),
        .vel        (vel),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    lnps_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .res        (res),
        .empty      (empty),
        .pop        (pop)
    );

    assign action     = res.action;
    assign out_chan   = res.chan;
    assign out_note   = res.note;
    assign out_vel    = res.vel;
    assign held_count = res.held;
    assign overflow   = res.ovf;

endmodule
`default_nettype wire

### tb/lnps_tb_pkg.sv
// Scoreboard and note stack predictor for the last-note-priority stack testbench
package lnps_tb_pkg;
    import lnps_pkg::*;

    localparam int STACK_SLOTS = 16;

    class note_stack_scoreboard;
        logic [NOTE_W-1:0] held_notes[STACK_SLOTS];
        int unsigned       held_total;
        lnps_res_t         expected_words[$];
        int unsigned       mismatches;

        function new();
            held_total = 0;
            mismatches = 0;
        endfunction

        function void drop_note(int unsigned pos);
            for (int unsigned i = pos; i + 1 < held_total; i++)
            begin
                held_notes[i] = held_notes[i + 1];
            end
            held_total--;
        endfunction

        function void note_event(lnps_item_t ev);
            lnps_res_t word;
            word        = '0;
            word.action = ACT_NONE;
            word.chan   = ev.chan;
            if (ev.op == OP_NOTE_ON)
            begin
                if (held_total >= STACK_SLOTS)
                begin
                    drop_note(0);
                    word.ovf = 1'b1;
                end
                held_notes[held_total] = ev.note;
                held_total++;
                word.action = ACT_TRIGGER;
                word.note   = ev.note;
                word.vel    = ev.vel;
            end
            else if (held_total > 0)
            begin
                if (held_notes[held_total - 1] == ev.note)
                begin
                    held_total--;
                    if (held_total == 0)
                    begin
                        word.action = ACT_RELEASE;
                        word.note   = ev.note;
                    end
                    else
                    begin
                        word.action = ACT_TRIGGER;
                        word.note   = held_notes[held_total - 1];
                    end
                    word.vel = ev.vel;
                end
                else
                begin
                    for (int i = int'(held_total) - 2; i >= 0; i--)
                    begin
                        if (held_notes[i] == ev.note)
                        begin
                            drop_note(i);
                            break;
                        end
                    end
                end
            end
            word.held = HELD_W'(held_total);
            expected_words.push_back(word);
        endfunction

        function void check_word(lnps_res_t got);
            lnps_res_t want;
            if (expected_words.size() == 0)
            begin
                $error("result word popped with nothing expected");
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.action !== want.action)
            begin
                $error("action: expected %0d, got %0d", want.action, got.action);
                mismatches++;
            end
            if (got.chan !== want.chan)
            begin
                $error("out_chan: expected %0d, got %0d", want.chan, got.chan);
                mismatches++;
            end
            if (got.note !== want.note)
            begin
                $error("out_note: expected %0d, got %0d", want.note, got.note);
                mismatches++;
            end
            if (got.vel !== want.vel)
            begin
                $error("out_vel: expected %0d, got %0d", want.vel, got.vel);
                mismatches++;
            end
            if (got.held !== want.held)
            begin
                $error("held_count: expected %0d, got %0d", want.held, got.held);
                mismatches++;
            end
            if (got.ovf !== want.ovf)
            begin
                $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

endpackage

### tb/tb_top.sv
// Top-level testbench of the last-note-priority note stack
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lnps_pkg::*;
    import lnps_tb_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              cmd;
    logic [CHAN_W-1:0] chan;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              empty;
    logic              pop;
    logic [1:0]        action;
    logic [CHAN_W-1:0] out_chan;
    logic [NOTE_W-1:0] out_note;
    logic [VEL_W-1:0]  out_vel;
    logic [HELD_W-1:0] held_count;
    logic              overflow;

    note_stack_scoreboard sb;
    bit                   sender_no_idle;

    last_note_priority_stack #(
        .STACK_DEPTH(STACK_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .cmd(cmd),
        .chan(chan),
        .note(note),
        .vel(vel),
        .empty(empty),
        .pop(pop),
        .action(action),
        .out_chan(out_chan),
        .out_note(out_note),
        .out_vel(out_vel),
        .held_count(held_count),
        .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic lnps_item_t make_event(op_t op, int unsigned ch, int unsigned nt,
                                              int unsigned vl);
        lnps_item_t ev;
        ev.op   = op;
        ev.chan = CHAN_W'(ch);
        ev.note = NOTE_W'(nt);
        ev.vel  = VEL_W'(vl);
        return ev;
    endfunction

    function automatic lnps_item_t draw_note_event(int unsigned on_weight);
        lnps_item_t  ev;
        int unsigned roll;
        int unsigned n;
        ev.chan = CHAN_W'($urandom_range(0, 15));
        ev.vel  = VEL_W'($urandom_range(0, 127));
        n       = sb.held_total;
        roll    = $urandom_range(0, 99);
        if ((n == 0) ? (roll < 90) : (roll < on_weight))
        begin
            ev.op = OP_NOTE_ON;
            if ($urandom_range(0, 1) != 0)
                ev.note = NOTE_W'($urandom_range(60, 67));
            else
                ev.note = NOTE_W'($urandom_range(0, 127));
        end
        else
        begin
            ev.op = OP_NOTE_OFF;
            roll  = $urandom_range(0, 99);
            if (n > 0 && roll < 60)
                ev.note = sb.held_notes[n - 1];
            else if (n > 0 && roll < 85)
                ev.note = sb.held_notes[$urandom_range(0, n - 1)];
            else
                ev.note = NOTE_W'($urandom_range(0, 127));
        end
        return ev;
    endfunction

    task automatic send_word(input lnps_item_t ev);
        int unsigned gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        cmd  <= ev.op;
        chan <= ev.chan;
        note <= ev.note;
        vel  <= ev.vel;
        do @(posedge clk); while (full);
        sb.note_event(ev);
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        push <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic directed_events();
        send_word(make_event(OP_NOTE_OFF, 15, 60, 127));
        send_word(make_event(OP_NOTE_ON, 15, 0, 127));
        send_word(make_event(OP_NOTE_ON, 0, 127, 0));
        send_word(make_event(OP_NOTE_ON, 5, 127, 1));
        send_word(make_event(OP_NOTE_OFF, 9, 127, 99));
        send_word(make_event(OP_NOTE_OFF, 3, 5, 77));
        send_word(make_event(OP_NOTE_ON, 10, 64, 64));
        send_word(make_event(OP_NOTE_OFF, 6, 127, 12));
        send_word(make_event(OP_NOTE_OFF, 7, 64, 100));
        send_word(make_event(OP_NOTE_OFF, 8, 0, 33));
        for (int i = 0; i < STACK_SLOTS; i++)
        begin
            send_word(make_event(OP_NOTE_ON, i, i * 8 + 3, i * 8));
        end
        send_word(make_event(OP_NOTE_ON, 15, 127, 127));
    endtask

    initial
    begin
        lnps_res_t   got;
        int unsigned taken;
        int unsigned wait_cycles;
        pop   = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            wait_cycles = (taken >= 400 && taken < 600) ? 0 : $urandom_range(0, 4);
            if (taken == 200 || taken == 1000)
                wait_cycles += 120;
            if (wait_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got.action = action_t'(action);
            got.chan   = out_chan;
            got.note   = out_note;
            got.vel    = out_vel;
            got.held   = held_count;
            got.ovf    = overflow;
            sb.check_word(got);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        int unsigned on_weight;
        sb             = new();
        sender_no_idle = 1'b0;
        on_weight      = 50;
        rst_n          = 1'b0;
        push           = 1'b0;
        cmd            = CMD_NOTE_ON;
        chan           = '0;
        note           = '0;
        vel            = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_events();
        pause_until_drained();

        for (int k = 0; k < 1620; k++)
        begin
            if (k % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       on_weight = 35;
                    1:       on_weight = 50;
                    2:       on_weight = 65;
                    default: on_weight = 85;
                endcase
            end
            if (k == 800)
                pause_until_drained();
            sender_no_idle = (k >= 400 && k < 600);
            send_word(draw_note_event(on_weight));
        end

        push <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (2 * STACK_SLOTS + 10) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lnps_pkg.sv
rtl/core/lnps_front.sv
rtl/core/lnps_back.sv
rtl/core/last_note_priority_stack.sv
tb/lnps_tb_pkg.sv
tb/tb_top.sv
